// ----- design/l2lh_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the log2 latency histogram.
// No dependencies; used by every module of the block.
package l2lh_pkg;

    localparam int NUM_BUCKETS_DEF = 24;
    localparam int NUM_BUCKETS_MAX = 32;

    localparam int REQ_W    = 2;
    localparam int SAMPLE_W = 32;
    localparam int PCT_W    = 7;
    localparam int CNT_W    = 48;
    localparam int SUM_W    = 64;
    localparam int PEAK_W   = 31;
    localparam int EDGE_W   = 37;
    localparam int TGT_W    = CNT_W + PCT_W;
    localparam int EDGE_BASE = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_OBSERVE = 2'd0,
        REQ_REPORT  = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OBS_WALK,
        ST_RPT_ACC,
        ST_RPT_CMP,
        ST_RPT_DIV
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_obs;
        logic load_rpt;
        logic clear;
        logic obs_step;
        logic obs_commit;
        logic rpt_acc;
        logic rpt_step;
        logic edge_latch;
        logic out_fire;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic obs_more;
        logic rpt_hit;
        logic idx_last;
        logic div_done;
    } t_dp_sts;

    // upper edge of bucket i: 16 << i
    function automatic logic [EDGE_W-1:0] edge_of(input logic [4:0] i);
        return EDGE_W'(EDGE_BASE) << i;
    endfunction

endpackage

// ----- design/log2_latency_histogram_unit.sv -----
`timescale 1ns / 1ps
// Top level of the log2 latency histogram: controller plus datapath.
// Depends on l2lh_pkg, l2lh_ctrl, l2lh_dp (which holds l2lh_div).
//
//  channel   direction  handshake                 payload
//  request   in         start & !busy             i_req_type, i_sample_us, i_percent
//  report    out        o_result_valid (1 cycle)  o_event_count, o_total_us, o_peak_us,
//                                                 o_average_us, o_pct_edge_us
//
// Per item:
//   clear   - takes effect at the accept edge.
//   observe - the bucket search steps one edge per cycle.
//   report  - waits on the 64-step restoring divider (sum / count);
//             the percentile walk (accumulate, then compare, per bucket) runs beside it.
// Reset is synchronous, active low, and zeroes all counters.
// The receiver cannot stall; a report is shown for exactly one cycle on
// o_result_valid, and busy drops in that same cycle.
module log2_latency_histogram_unit #(
    parameter int NUM_BUCKETS = l2lh_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [l2lh_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [l2lh_pkg::SAMPLE_W-1:0] i_sample_us,
    input  logic [l2lh_pkg::PCT_W-1:0]           i_percent,
    output logic                                 o_result_valid,
    output logic [l2lh_pkg::CNT_W-1:0]           o_event_count,
    output logic [l2lh_pkg::SUM_W-1:0]           o_total_us,
    output logic [l2lh_pkg::PEAK_W-1:0]          o_peak_us,
    output logic [l2lh_pkg::SUM_W-1:0]           o_average_us,
    output logic [l2lh_pkg::EDGE_W-1:0]          o_pct_edge_us
);
    l2lh_pkg::t_dp_cmd w_cmd;
    l2lh_pkg::t_dp_sts w_sts;

    // sequencer: one item at a time
    l2lh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .busy       (busy),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // counters, bucket walk, divider and result registers
    l2lh_dp #(
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample_us    (i_sample_us),
        .i_percent      (i_percent),
        .o_result_valid (o_result_valid),
        .o_event_count  (o_event_count),
        .o_total_us     (o_total_us),
        .o_peak_us      (o_peak_us),
        .o_average_us   (o_average_us),
        .o_pct_edge_us  (o_pct_edge_us)
    );

endmodule

// ----- design/l2lh_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle (sum / count).
// Depends on l2lh_pkg for widths.
module l2lh_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [l2lh_pkg::SUM_W-1:0] i_dividend,
    input  logic [l2lh_pkg::CNT_W-1:0] i_divisor,
    output logic [l2lh_pkg::SUM_W-1:0] o_quotient,
    output logic                       o_done
);
    localparam int SW = l2lh_pkg::SUM_W;
    localparam int CW = l2lh_pkg::CNT_W;
    localparam int NW = $clog2(SW);

    logic          r_run;
    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [SW-1:0] r_quo;
    logic [CW-1:0] r_dvs;
    logic [CW:0]   w_shift;
    logic          w_ge;

    assign w_shift = {r_rem, r_quo[SW-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_run <= 1'b1;
            r_cnt <= NW'(SW - 1);
        end else if (r_run) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= w_ge ? CW'(w_shift - {1'b0, r_dvs}) : w_shift[CW-1:0];
            r_quo <= {r_quo[SW-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = !r_run;

endmodule

// ----- design/l2lh_dp.sv -----
`timescale 1ns / 1ps
// Datapath: bucket counters, totals, bucket walk, percentile compare, result regs.
// Depends on l2lh_pkg and l2lh_div.
module l2lh_dp #(
    parameter int NUM_BUCKETS = l2lh_pkg::NUM_BUCKETS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  l2lh_pkg::t_dp_cmd                  i_cmd,
    output l2lh_pkg::t_dp_sts                  o_sts,
    input  logic signed [l2lh_pkg::SAMPLE_W-1:0] i_sample_us,
    input  logic [l2lh_pkg::PCT_W-1:0]         i_percent,
    output logic                               o_result_valid,
    output logic [l2lh_pkg::CNT_W-1:0]         o_event_count,
    output logic [l2lh_pkg::SUM_W-1:0]         o_total_us,
    output logic [l2lh_pkg::PEAK_W-1:0]        o_peak_us,
    output logic [l2lh_pkg::SUM_W-1:0]         o_average_us,
    output logic [l2lh_pkg::EDGE_W-1:0]        o_pct_edge_us
);
    localparam int CW   = l2lh_pkg::CNT_W;
    localparam int SW   = l2lh_pkg::SUM_W;
    localparam int PW   = l2lh_pkg::PEAK_W;
    localparam int EW   = l2lh_pkg::EDGE_W;
    localparam int TW   = l2lh_pkg::TGT_W;
    localparam int IDXW = $clog2(NUM_BUCKETS);
    localparam int RUNW = CW + $clog2(NUM_BUCKETS);
    localparam int MULW = RUNW + 7;

    logic [CW-1:0]   r_bkt [NUM_BUCKETS];
    logic [CW-1:0]   r_count;
    logic [SW-1:0]   r_sum;
    logic [PW-1:0]   r_peak;
    logic [PW-1:0]   r_v;
    logic [IDXW-1:0] r_idx;
    logic [RUNW-1:0] r_running;
    logic [TW-1:0]   r_target;
    logic [EW-1:0]   r_edge;
    logic            r_valid;

    logic [EW-1:0]   w_edge;
    logic [MULW-1:0] w_run100;
    logic [SW-1:0]   w_quo;
    logic            w_div_done;

    l2lh_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load_rpt),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    assign w_edge   = l2lh_pkg::edge_of(5'(r_idx));
    // running * 100 as shift-add
    assign w_run100 = (MULW'(r_running) << 6) + (MULW'(r_running) << 5)
                    + (MULW'(r_running) << 2);

    assign o_sts.idx_last = (r_idx == IDXW'(NUM_BUCKETS - 1));
    assign o_sts.obs_more = !o_sts.idx_last && (EW'(r_v) > w_edge);
    assign o_sts.rpt_hit  = (w_run100 >= MULW'(r_target));
    assign o_sts.div_done = w_div_done;

    // histogram state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                r_bkt[i] <= '0;
            end
            r_count <= '0;
            r_sum   <= '0;
            r_peak  <= '0;
        end else if (i_cmd.obs_commit) begin
            r_bkt[r_idx] <= r_bkt[r_idx] + 1'b1;
            r_count      <= r_count + 1'b1;
            r_sum        <= r_sum + SW'(r_v);
            if (r_v > r_peak) begin
                r_peak <= r_v;
            end
        end
    end

    // walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_obs) begin
            r_v   <= i_sample_us[l2lh_pkg::SAMPLE_W-1] ? '0 : i_sample_us[PW-1:0];
            r_idx <= '0;
        end else if (i_cmd.load_rpt) begin
            r_idx     <= '0;
            r_running <= '0;
            r_target  <= TW'(i_percent) * TW'(r_count);
        end else begin
            if (i_cmd.obs_step || i_cmd.rpt_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.rpt_acc) begin
                r_running <= r_running + RUNW'(r_bkt[r_idx]);
            end
        end
        if (i_cmd.edge_latch) begin
            r_edge <= (r_count == '0) ? '0 : w_edge;
        end
    end

    // result registers, strobe for one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.out_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_fire) begin
            o_event_count <= r_count;
            o_total_us    <= r_sum;
            o_peak_us     <= r_peak;
            o_average_us  <= (r_count == '0) ? '0 : w_quo;
            o_pct_edge_us <= r_edge;
        end
    end

    assign o_result_valid = r_valid;

endmodule

// ----- design/l2lh_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences observe walks, report walks and the divide wait.
// Depends on l2lh_pkg.
module l2lh_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [l2lh_pkg::REQ_W-1:0]   i_req_type,
    output logic                         busy,
    output l2lh_pkg::t_dp_cmd            o_cmd,
    input  l2lh_pkg::t_dp_sts            i_sts
);
    l2lh_pkg::t_state r_state;
    l2lh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= l2lh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != l2lh_pkg::ST_IDLE);
        case (r_state)
            l2lh_pkg::ST_IDLE: begin
                if (start) begin
                    case (l2lh_pkg::t_req'(i_req_type))
                        l2lh_pkg::REQ_OBSERVE: begin
                            o_cmd.load_obs = 1'b1;
                            n_state        = l2lh_pkg::ST_OBS_WALK;
                        end
                        l2lh_pkg::REQ_REPORT: begin
                            o_cmd.load_rpt = 1'b1;
                            n_state        = l2lh_pkg::ST_RPT_ACC;
                        end
                        l2lh_pkg::REQ_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            l2lh_pkg::ST_OBS_WALK: begin
                if (i_sts.obs_more) begin
                    o_cmd.obs_step = 1'b1;
                end else begin
                    o_cmd.obs_commit = 1'b1;
                    n_state          = l2lh_pkg::ST_IDLE;
                end
            end
            l2lh_pkg::ST_RPT_ACC: begin
                o_cmd.rpt_acc = 1'b1;
                n_state       = l2lh_pkg::ST_RPT_CMP;
            end
            l2lh_pkg::ST_RPT_CMP: begin
                // last bucket edge is also the answer when nothing reaches target
                if (i_sts.rpt_hit || i_sts.idx_last) begin
                    o_cmd.edge_latch = 1'b1;
                    n_state          = l2lh_pkg::ST_RPT_DIV;
                end else begin
                    o_cmd.rpt_step = 1'b1;
                    n_state        = l2lh_pkg::ST_RPT_ACC;
                end
            end
            l2lh_pkg::ST_RPT_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.out_fire = 1'b1;
                    n_state        = l2lh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = l2lh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for log2_latency_histogram_unit: drives observe, report and
// clear items and checks every report against its own histogram predictor.
// Depends on l2lh_pkg and the design sources under design/.
module tb_top;

    localparam int NB          = l2lh_pkg::NUM_BUCKETS_DEF;
    localparam int RAND_ITEMS  = 650;
    localparam int CYCLE_LIMIT = 400000;

    localparam int CNT_W    = l2lh_pkg::CNT_W;
    localparam int SUM_W    = l2lh_pkg::SUM_W;
    localparam int PEAK_W   = l2lh_pkg::PEAK_W;
    localparam int EDGE_W   = l2lh_pkg::EDGE_W;
    localparam int SAMPLE_W = l2lh_pkg::SAMPLE_W;
    localparam int PCT_W    = l2lh_pkg::PCT_W;

    // one report as the block shows it on the result ports
    typedef struct {
        logic [CNT_W-1:0]  event_count;
        logic [SUM_W-1:0]  total_us;
        logic [PEAK_W-1:0] peak_us;
        logic [SUM_W-1:0]  average_us;
        logic [EDGE_W-1:0] pct_edge_us;
    } t_report;

    // Keeps a shadow histogram, predicts each report when its item is accepted
    // and holds the predictions until the block shows them.
    class histogram_scoreboard;
        logic [CNT_W-1:0]  bucket_tally [NB];
        logic [CNT_W-1:0]  seen_count;
        logic [SUM_W-1:0]  seen_sum;
        logic [PEAK_W-1:0] seen_peak;
        t_report           reports_due [$];
        int                fail_count;

        function new();
            wipe();
            fail_count = 0;
        endfunction

        function void wipe();
            foreach (bucket_tally[i]) bucket_tally[i] = '0;
            seen_count = '0;
            seen_sum   = '0;
            seen_peak  = '0;
        endfunction

        // upper edge of bucket i, 16 << i
        function logic [EDGE_W-1:0] bucket_top(int i);
            return EDGE_W'(64'd16 << i);
        endfunction

        function void note_item(l2lh_pkg::t_req req, logic signed [SAMPLE_W-1:0] sample,
                                logic [PCT_W-1:0] pct);
            logic [63:0] v;
            logic [63:0] target;
            logic [63:0] running;
            int          idx;
            t_report     want;
            bit          found;
            case (req)
                l2lh_pkg::REQ_OBSERVE: begin
                    // negative samples count as zero
                    v = sample[SAMPLE_W-1] ? 64'd0 : 64'(sample[SAMPLE_W-2:0]);
                    idx = 0;
                    while (idx + 1 < NB && v > 64'(bucket_top(idx)))
                        idx++;
                    bucket_tally[idx] = bucket_tally[idx] + 1'b1;
                    seen_count = seen_count + 1'b1;
                    seen_sum   = seen_sum + v;
                    if (v[PEAK_W-1:0] > seen_peak)
                        seen_peak = v[PEAK_W-1:0];
                end
                l2lh_pkg::REQ_REPORT: begin
                    want.event_count = seen_count;
                    want.total_us    = seen_sum;
                    want.peak_us     = seen_peak;
                    want.average_us  = (seen_count == '0) ? '0 : seen_sum / 64'(seen_count);
                    want.pct_edge_us = '0;
                    if (seen_count != '0) begin
                        // running total kept in 64 bits; fall back to the last edge
                        target  = 64'(pct) * 64'(seen_count);
                        running = '0;
                        found   = 1'b0;
                        for (int i = 0; i < NB; i++) begin
                            running = running + 64'(bucket_tally[i]);
                            if (!found && running * 64'd100 >= target) begin
                                want.pct_edge_us = bucket_top(i);
                                found = 1'b1;
                            end
                        end
                        if (!found)
                            want.pct_edge_us = bucket_top(NB - 1);
                    end
                    reports_due.push_back(want);
                end
                l2lh_pkg::REQ_CLEAR: wipe();
                default: ;  // unused code: no effect
            endcase
        endfunction

        function void check_result(t_report got);
            t_report want;
            if (reports_due.size() == 0) begin
                $error("report with no item pending: count %0d", got.event_count);
                fail_count++;
                return;
            end
            want = reports_due.pop_front();
            if (got.event_count !== want.event_count) begin
                $error("event_count: expected %0d, actual %0d", want.event_count,
                       got.event_count);
                fail_count++;
            end
            if (got.total_us !== want.total_us) begin
                $error("total_us: expected %0d, actual %0d", want.total_us, got.total_us);
                fail_count++;
            end
            if (got.peak_us !== want.peak_us) begin
                $error("peak_us: expected %0d, actual %0d", want.peak_us, got.peak_us);
                fail_count++;
            end
            if (got.average_us !== want.average_us) begin
                $error("average_us: expected %0d, actual %0d", want.average_us,
                       got.average_us);
                fail_count++;
            end
            if (got.pct_edge_us !== want.pct_edge_us) begin
                $error("pct_edge_us: expected %0d, actual %0d", want.pct_edge_us,
                       got.pct_edge_us);
                fail_count++;
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    l2lh_pkg::t_req               i_req_type;
    logic signed [SAMPLE_W-1:0]   i_sample_us;
    logic [PCT_W-1:0]             i_percent;
    logic                         o_result_valid;
    logic [CNT_W-1:0]             o_event_count;
    logic [SUM_W-1:0]             o_total_us;
    logic [PEAK_W-1:0]            o_peak_us;
    logic [SUM_W-1:0]             o_average_us;
    logic [EDGE_W-1:0]            o_pct_edge_us;

    histogram_scoreboard stats_board = new();
    bit                  gaps_on;
    int                  cycle_count;
    t_report             seen_report;

    log2_latency_histogram_unit #(
        .NUM_BUCKETS (NB)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_sample_us    (i_sample_us),
        .i_percent      (i_percent),
        .o_result_valid (o_result_valid),
        .o_event_count  (o_event_count),
        .o_total_us     (o_total_us),
        .o_peak_us      (o_peak_us),
        .o_average_us   (o_average_us),
        .o_pct_edge_us  (o_pct_edge_us)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Hard stop in case the handshake hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Reports live for exactly one cycle; values read here are the ones
    // present just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            seen_report.event_count = o_event_count;
            seen_report.total_us    = o_total_us;
            seen_report.peak_us     = o_peak_us;
            seen_report.average_us  = o_average_us;
            seen_report.pct_edge_us = o_pct_edge_us;
            stats_board.check_result(seen_report);
        end
    end

    // Present one item and hold it until start & !busy at an edge. Called at
    // a rising edge. Start stays high into the next item unless a gap is taken.
    task automatic send_item(input l2lh_pkg::t_req req,
                             input logic signed [SAMPLE_W-1:0] sample,
                             input logic [PCT_W-1:0] pct);
        int gap;
        i_req_type  <= req;
        i_sample_us <= sample;
        i_percent   <= pct;
        start       <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        stats_board.note_item(req, sample, pct);
        if (gaps_on && $urandom_range(99) < 11) begin
            // short gaps mostly; long ones can land after the block has gone idle
            gap = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 90);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Samples spread over the buckets, with exact edges, negatives and
    // full-width values in the mix.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int unsigned e;
        case ($urandom_range(9))
            0: return {1'b1, 31'($urandom)};
            1: return $urandom;
            2: begin
                e = $urandom_range(0, 27);
                return 32'((64'd16 << e) + 64'($urandom_range(0, 1)));
            end
            3: return 32'($urandom_range(0, 16));
            default: begin
                e = $urandom_range(0, 23);
                return 32'($urandom_range(0, 16 << e));
            end
        endcase
    endfunction

    function automatic logic [PCT_W-1:0] pick_percent();
        if ($urandom_range(99) < 90)
            return PCT_W'($urandom_range(0, 100));
        return PCT_W'($urandom_range(101, 127));
    endfunction

    initial begin
        int             counted;
        int             pick;
        l2lh_pkg::t_req req;
        cycle_count  = 0;
        gaps_on      = 1'b1;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_req_type  <= l2lh_pkg::REQ_NONE;
        i_sample_us <= '0;
        i_percent   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: empty reports, bucket edges, clamps, unused code, clear
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd50);
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd127);
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sh8000_0000, 7'd0);  // most negative
        send_item(l2lh_pkg::REQ_OBSERVE, -32'sd1, 7'd0);
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sd0, 7'd0);
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sd16, 7'd0);          // top of first bucket
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sd17, 7'd0);
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sd32, 7'd0);
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sd33, 7'd0);
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sh0800_0000, 7'd0);  // top of last bucket
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sh0800_0001, 7'd0);  // beyond every edge
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sh7FFF_FFFF, 7'd0);
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd0);
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd50);
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd100);
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd127);          // above 100
        send_item(l2lh_pkg::REQ_NONE, 32'sh7FFF_FFFF, 7'd127);    // ignored
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd99);
        send_item(l2lh_pkg::REQ_CLEAR, 32'sd0, 7'd0);
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd100);
        send_item(l2lh_pkg::REQ_OBSERVE, 32'sd5, 7'd0);
        send_item(l2lh_pkg::REQ_REPORT, 32'sd0, 7'd1);

        // --- random: mostly observes, reports spread through, rare clears.
        // Items 250..399 run back to back with no gaps.
        counted = 0;
        while (counted < RAND_ITEMS) begin
            gaps_on = !(counted >= 250 && counted < 400);
            pick = $urandom_range(99);
            if (pick < 70)
                req = l2lh_pkg::REQ_OBSERVE;
            else if (pick < 89)
                req = l2lh_pkg::REQ_REPORT;
            else if (pick < 93)
                req = l2lh_pkg::REQ_CLEAR;
            else
                req = l2lh_pkg::REQ_NONE;
            counted++;
            send_item(req, pick_sample(), pick_percent());
        end
        start <= 1'b0;

        // drain, then allow a report's worth of cycles for any stray result
        while (stats_board.reports_due.size() != 0)
            @(posedge i_clk);
        repeat (NB + 100) @(posedge i_clk);

        if (stats_board.fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/l2lh_pkg.sv
design/l2lh_div.sv
design/l2lh_dp.sv
design/l2lh_ctrl.sv
design/log2_latency_histogram_unit.sv
verif/tb_top.sv
